>>> rtl/asrg_pkg.sv
// Shared types, codes and constants for the angular sector ray geometry block.
`default_nettype none
package asrg_pkg;
	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_LOCATE = 2'd1;
	localparam logic [1:0] FUNC_RAY = 2'd2;
	localparam logic [1:0] FUNC_NEAR = 2'd3;

	localparam logic signed [31:0] NORM_MAX = 32'sh4000_0000;
	localparam logic signed [31:0] NORM_MIN = -32'sh4000_0000;

	// MAC unit controls
	typedef struct packed {
		logic clr;
		logic acc;
	} mac_ctl_t;

	// divider controls
	typedef struct packed {
		logic start;
	} div_ctl_t;

	function automatic logic signed [31:0] clamp_norm(input logic signed [31:0] v);
		logic signed [31:0] r;
		r = v;
		if (v > NORM_MAX) r = NORM_MAX;
		if (v < NORM_MIN) r = NORM_MIN;
		return r;
	endfunction

	function automatic logic signed [63:0] sat64(input logic signed [65:0] v);
		logic signed [63:0] r;
		r = v[63:0];
		if (v > 66'sh0_7FFF_FFFF_FFFF_FFFF) r = 64'sh7FFF_FFFF_FFFF_FFFF;
		if (v < -66'sh0_8000_0000_0000_0000) r = 64'sh8000_0000_0000_0000;
		return r;
	endfunction
endpackage
`default_nettype wire

>>> rtl/asrg_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module asrg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

>>> rtl/asrg_mac.sv
// Shared multiply-accumulate: one 32x32 product per cycle into a 66-bit sum.
`default_nettype none
module asrg_mac (
	input wire logic clk,
	input wire asrg_pkg::mac_ctl_t ctl,
	input wire logic signed [31:0] a,
	input wire logic signed [31:0] b,
	output logic signed [65:0] acc
);
	import asrg_pkg::*;
	logic signed [63:0] prod_s1;
	logic clr_s1, acc_s1;

	// product register, then accumulate
	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		clr_s1 <= ctl.clr;
		acc_s1 <= ctl.acc;
		if (clr_s1) acc <= 66'(prod_s1);
		else if (acc_s1) acc <= acc + 66'(prod_s1);
	end
endmodule
`default_nettype wire

>>> rtl/asrg_div.sv
// Radix-2 signed divider: truncating, saturated to 32 bits, one bit a cycle.
`default_nettype none
module asrg_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire asrg_pkg::div_ctl_t ctl,
	input wire logic signed [63:0] num,
	input wire logic signed [63:0] den,
	output logic busy,
	output logic signed [31:0] quo
);
	import asrg_pkg::*;
	logic [63:0] rem_q, dv_q, q_q;
	logic [6:0] cnt_q;
	logic neg_q;
	logic [64:0] trial;
	logic [63:0] un, ud;

	assign un = num[63] ? 64'(-num) : num;
	assign ud = den[63] ? 64'(-den) : den;
	assign trial = {rem_q, q_q[63]} - {1'b0, dv_q};

	// one quotient bit per cycle, shifted in from the bottom of q_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			cnt_q <= '0;
		end else if (ctl.start) begin
			busy <= 1'b1;
			cnt_q <= 7'd64;
			rem_q <= '0;
			q_q <= un;
			dv_q <= ud;
			neg_q <= num[63] ^ den[63];
		end else if (busy) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], q_q[63]};
				q_q <= {q_q[62:0], 1'b0};
			end
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1) busy <= 1'b0;
		end
	end

	// saturate magnitude and apply sign
	always_comb begin
		logic [32:0] mag;
		mag = (q_q[63:32] != 0) ? 33'h1_0000_0000 : {1'b0, q_q[31:0]};
		if (neg_q) quo = (mag > 33'h0_8000_0000) ? 32'sh8000_0000 : 32'(-mag);
		else quo = (mag > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : mag[31:0];
	end
endmodule
`default_nettype wire

>>> rtl/angular_sector_ray_geometry.sv
// Top level: plane table, sequencer, shared MAC and divider.
`default_nettype none
// One item at a time; start is taken when busy is low, and exactly one result
// follows as a one-cycle done strobe. A write, or a ray or nearest query on a
// bad sector, goes straight to the result; a locate takes one plane dot product
// per plane in use. Each plane dot product runs on the shared MAC (read, three
// products, drain, evaluate), and each of the up to two serial 64-bit divisions
// of a ray query yields one quotient bit per cycle.
// The receiver cannot stall; results must be taken when done is high.
module angular_sector_ray_geometry #(
	parameter int MAX_PLANES = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [4:0] cfg_wdata,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] func,
	input wire logic [3:0] index,
	input wire logic signed [31:0] pos_x,
	input wire logic signed [31:0] pos_y,
	input wire logic signed [31:0] pos_z,
	input wire logic signed [31:0] dir_x,
	input wire logic signed [31:0] dir_y,
	input wire logic signed [31:0] dir_z,
	input wire logic signed [31:0] limit,
	output logic done,
	output logic [3:0] region,
	output logic signed [31:0] distance,
	output logic crossed,
	output logic signed [31:0] hit_norm_x,
	output logic signed [31:0] hit_norm_y,
	output logic signed [31:0] hit_norm_z,
	output logic bad_index
);
	import asrg_pkg::*;
	localparam int AW = $clog2(MAX_PLANES);
	localparam int CW = $clog2(MAX_PLANES + 1);

	localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_MAC = 4'd2, S_WAIT = 4'd3,
		S_EVAL = 4'd4, S_DIV = 4'd5, S_DIVW = 4'd6, S_OUT = 4'd7;

	logic [3:0] st_q;
	logic [CW-1:0] n_q;
	logic [1:0] func_q;
	logic [3:0] idx_q;
	logic signed [31:0] px_q, py_q, pz_q, dx_q, dy_q, dz_q;
	logic [CW-1:0] j_q;     // plane being processed
	logic phase_q;          // 0 point dot, 1 direction dot
	logic [1:0] k_q;        // MAC term
	logic [1:0] wt_q;
	logic pass_q;           // ray/near: 0 lower, 1 upper
	logic signed [63:0] pdot_q, prev_q, t1_q, num_q;
	logic signed [31:0] t_q;
	logic [3:0] reg_q;
	logic cr_q, bad_q;
	logic signed [31:0] hx_q, hy_q, hz_q;
	logic found_q;

	// clamp register write
	logic [CW-1:0] n_wr;
	always_comb begin
		n_wr = (cfg_wdata < 5'd2) ? CW'(2) :
			(32'(cfg_wdata) > MAX_PLANES) ? CW'(MAX_PLANES) : CW'(cfg_wdata);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) n_q <= CW'(2);
		else if (cfg_we) n_q <= n_wr;
	end

	// plane table
	logic we;
	logic [AW-1:0] ra;
	logic signed [31:0] nx, ny, nz, off;
	assign we = start && !busy && func == FUNC_WRITE && 32'(index) < MAX_PLANES;
	assign ra = we ? AW'(index) : AW'(j_q);
	asrg_ram #(.WIDTH(32), .DEPTH(MAX_PLANES)) u_nx (.clk, .we, .addr(ra),
		.wdata(clamp_norm(dir_x)), .rdata(nx));
	asrg_ram #(.WIDTH(32), .DEPTH(MAX_PLANES)) u_ny (.clk, .we, .addr(ra),
		.wdata(clamp_norm(dir_y)), .rdata(ny));
	asrg_ram #(.WIDTH(32), .DEPTH(MAX_PLANES)) u_nz (.clk, .we, .addr(ra),
		.wdata(clamp_norm(dir_z)), .rdata(nz));
	asrg_ram #(.WIDTH(32), .DEPTH(MAX_PLANES)) u_off (.clk, .we, .addr(ra),
		.wdata(limit), .rdata(off));

	// MAC operand select
	mac_ctl_t mctl;
	logic signed [31:0] ma, mb;
	logic signed [65:0] acc;
	always_comb begin
		mctl = '0;
		ma = nx;
		mb = phase_q ? dx_q : px_q;
		case (k_q)
			2'd1: begin ma = ny; mb = phase_q ? dy_q : py_q; end
			2'd2: begin ma = nz; mb = phase_q ? dz_q : pz_q; end
			default: ;
		endcase
		if (st_q == S_MAC) begin
			mctl.clr = (k_q == 2'd0);
			mctl.acc = (k_q != 2'd0);
		end
	end
	asrg_mac u_mac (.clk, .ctl(mctl), .a(ma), .b(mb), .acc);

	// divider
	div_ctl_t dctl;
	logic dbusy;
	logic signed [31:0] quo;
	logic signed [63:0] den_w;
	assign den_w = t1_q;
	assign dctl.start = (st_q == S_DIV);
	asrg_div u_div (.clk, .arst_n, .ctl(dctl), .num(num_q), .den(den_w),
		.busy(dbusy), .quo);

	// derived values
	logic [CW-1:0] up_j;
	logic signed [65:0] off46;
	logic signed [63:0] dot64, dirq;
	logic signed [65:0] dtrunc;
	assign up_j = (32'(idx_q) + 1 >= 32'(n_q)) ? '0 : CW'(idx_q + 4'd1);
	assign off46 = 66'(off) <<< 30;
	assign dot64 = acc[63:0];
	// truncate toward zero to Q.30
	assign dtrunc = (acc < 0) ? -((-acc) >>> 30) : (acc >>> 30);
	assign dirq = dtrunc[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done <= 1'b0;
		end else begin
			done <= (st_q == S_OUT);
			unique case (st_q)
				S_IDLE: if (start && !busy) begin
					func_q <= func; idx_q <= index;
					px_q <= pos_x; py_q <= pos_y; pz_q <= pos_z;
					dx_q <= clamp_norm(dir_x); dy_q <= clamp_norm(dir_y);
					dz_q <= clamp_norm(dir_z);
					reg_q <= '0; t_q <= limit; cr_q <= 1'b0; found_q <= 1'b0;
					hx_q <= '0; hy_q <= '0; hz_q <= '0;
					bad_q <= (CW'(index) >= n_q) || (32'(index) >= MAX_PLANES);
					phase_q <= 1'b0; pass_q <= 1'b0; k_q <= '0;
					j_q <= (func == FUNC_LOCATE) ? '0 : CW'(index);
					if (func == FUNC_WRITE) st_q <= S_OUT;
					else if (func == FUNC_LOCATE) st_q <= S_RD;
					else if (CW'(index) >= n_q) st_q <= S_OUT;
					else st_q <= S_RD;
				end
				S_RD: begin k_q <= '0; st_q <= S_MAC; end
				S_MAC: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd2) begin wt_q <= '0; st_q <= S_WAIT; end
				end
				S_WAIT: begin
					wt_q <= wt_q + 2'd1;
					if (wt_q == 2'd1) st_q <= S_EVAL;
				end
				S_EVAL: begin
					logic hit;
					logic signed [63:0] t2, m, q;
					hit = j_q != 0 && !found_q && prev_q >= t1_q && off46 > acc;
					if (func_q == FUNC_LOCATE) begin
						if (hit) begin
							reg_q <= 4'(j_q - 1'b1); found_q <= 1'b1;
						end else if (j_q == n_q - 1'b1 && !found_q) begin
							reg_q <= 4'(n_q - 1'b1);
						end
						prev_q <= dot64; t1_q <= off46[63:0];
						if (j_q == n_q - 1'b1) st_q <= S_OUT;
						else begin
							j_q <= j_q + 1'b1; st_q <= S_RD;
						end
					end else if (func_q == FUNC_NEAR) begin
						if (!pass_q) begin
							t1_q <= sat64(acc - off46);
							pass_q <= 1'b1; j_q <= up_j; st_q <= S_RD;
						end else begin
							t2 = sat64(off46 - acc);
							m = (t1_q < t2) ? t1_q : t2;
							// floor, then step toward zero when negative and inexact
							q = (m >>> 30) + $signed({63'd0, m[63] && (m[29:0] != 30'd0)});
							if (q > 64'sd2147483647) t_q <= 32'sh7FFF_FFFF;
							else if (q < -64'sd2147483648) t_q <= 32'sh8000_0000;
							else t_q <= q[31:0];
							st_q <= S_OUT;
						end
					end else if (!phase_q) begin
						// point dot done; numerator, then direction dot
						num_q <= sat64(off46 - acc);
						phase_q <= 1'b1;
						st_q <= S_RD;
					end else begin
						t1_q <= dirq;
						if ((!pass_q && dirq < 0) || (pass_q && dirq > 0)) st_q <= S_DIV;
						else if (!pass_q) begin
							pass_q <= 1'b1; phase_q <= 1'b0; j_q <= up_j; st_q <= S_RD;
						end else st_q <= S_OUT;
					end
				end
				S_DIV: st_q <= S_DIVW;
				S_DIVW: if (!dbusy) begin
					if (!pass_q) begin
						if (quo <= t_q) begin
							t_q <= quo; cr_q <= 1'b1;
							reg_q <= (idx_q == 4'd0) ? 4'(n_q - 1'b1) : idx_q - 4'd1;
							hx_q <= nx; hy_q <= ny; hz_q <= nz;
						end
						pass_q <= 1'b1; phase_q <= 1'b0; j_q <= up_j; st_q <= S_RD;
					end else begin
						if (quo < t_q) begin
							t_q <= quo; cr_q <= 1'b1; reg_q <= 4'(j_q);
							hx_q <= -nx; hy_q <= -ny; hz_q <= -nz;
						end
						st_q <= S_OUT;
					end
				end
				S_OUT: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// result fields, zero where meaningless
	always_comb begin
		logic q;
		q = (func_q == FUNC_RAY || func_q == FUNC_NEAR) && bad_q;
		region = (func_q == FUNC_WRITE || q) ? '0 :
			(func_q == FUNC_NEAR) ? '0 : (func_q == FUNC_RAY ? reg_q : reg_q);
		if (func_q == FUNC_RAY && !q && !cr_q) region = idx_q;
		distance = (func_q == FUNC_RAY || func_q == FUNC_NEAR) && !q ? t_q : '0;
		crossed = (func_q == FUNC_RAY) && !q && cr_q;
		hit_norm_x = crossed ? hx_q : '0;
		hit_norm_y = crossed ? hy_q : '0;
		hit_norm_z = crossed ? hz_q : '0;
		bad_index = (func_q == FUNC_WRITE) ? (CW'(idx_q) >= n_q) : q;
	end

	assign busy = (st_q != S_IDLE) || done;

	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held two cycles");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");
	a_n_range: assert property (@(posedge clk) disable iff (!arst_n)
		n_q >= CW'(2)) else $error("plane count below two");
endmodule
`default_nettype wire

>>> test/asrg_checker.sv
// Checker for the angular sector ray geometry block: predicts each item's result and compares.
`timescale 1ns / 1ps
module asrg_checker #(
	parameter int MAX_PLANES = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [4:0] cfg_wdata,
	input wire logic start,
	input wire logic busy,
	input wire logic [1:0] func,
	input wire logic [3:0] index,
	input wire logic signed [31:0] pos_x,
	input wire logic signed [31:0] pos_y,
	input wire logic signed [31:0] pos_z,
	input wire logic signed [31:0] dir_x,
	input wire logic signed [31:0] dir_y,
	input wire logic signed [31:0] dir_z,
	input wire logic signed [31:0] limit,
	input wire logic done,
	input wire logic [3:0] region,
	input wire logic signed [31:0] distance,
	input wire logic crossed,
	input wire logic signed [31:0] hit_norm_x,
	input wire logic signed [31:0] hit_norm_y,
	input wire logic signed [31:0] hit_norm_z,
	input wire logic bad_index,
	output int errors,
	output int pending
);
	import asrg_pkg::*;

	localparam longint ONE30 = 64'sd1073741824;

	typedef struct {
		logic [3:0] region;
		logic signed [31:0] distance;
		logic crossed;
		logic signed [31:0] hx;
		logic signed [31:0] hy;
		logic signed [31:0] hz;
		logic bad;
	} sector_result_t;

	// model copy of the plane table and the plane count
	longint plane_nx[MAX_PLANES];
	longint plane_ny[MAX_PLANES];
	longint plane_nz[MAX_PLANES];
	longint plane_off[MAX_PLANES];
	int unsigned planes_used;
	sector_result_t expected_results[$];

	assign pending = expected_results.size();

	function automatic longint norm_clip(logic signed [31:0] v);
		longint r;
		r = longint'(v);
		if (r > ONE30) r = ONE30;
		if (r < -ONE30) r = -ONE30;
		return r;
	endfunction

	function automatic longint diff_sat(longint a, longint b);
		logic signed [65:0] d;
		d = 66'(a) - 66'(b);
		if (d > 66'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (d < -66'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
		return longint'(d);
	endfunction

	function automatic longint clip32(logic signed [65:0] v);
		if (v > 66'sd2147483647) return 64'sd2147483647;
		if (v < -66'sd2147483648) return -64'sd2147483648;
		return longint'(v);
	endfunction

	// quotient truncated toward zero, saturated to 32 bits
	function automatic longint ray_div(longint num, longint den);
		logic signed [65:0] q;
		q = 66'(num) / 66'(den);
		return clip32(q);
	endfunction

	function automatic longint plane_dot(int k, longint x, longint y, longint z);
		return plane_nx[k] * x + plane_ny[k] * y + plane_nz[k] * z;
	endfunction

	function automatic sector_result_t predict_sector(logic [1:0] f, logic [3:0] idx,
			longint px, longint py, longint pz, longint dx, longint dy, longint dz, longint lim);
		sector_result_t r;
		int unsigned n;
		int unsigned up_j;
		int unsigned j;
		longint prev, cur, t, t1, t2, den, m;
		logic found;
		r = '{default: '0};
		n = planes_used;
		up_j = (idx + 1 >= n) ? 0 : idx + 1;
		case (f)
			FUNC_WRITE: begin
				r.bad = (idx >= n);
				if (idx < MAX_PLANES) begin
					plane_nx[idx] = dx;
					plane_ny[idx] = dy;
					plane_nz[idx] = dz;
					plane_off[idx] = lim;
				end
			end
			FUNC_LOCATE: begin
				// first sector whose lower plane is passed and upper plane is not
				r.region = 4'(n - 1);
				found = 1'b0;
				prev = plane_dot(0, px, py, pz);
				for (j = 1; j < n; j++) begin
					cur = plane_dot(j, px, py, pz);
					if (!found && prev >= plane_off[j - 1] * ONE30 && cur < plane_off[j] * ONE30) begin
						r.region = 4'(j - 1);
						found = 1'b1;
					end
					prev = cur;
				end
			end
			default: begin
				if (idx >= n) begin
					r.bad = 1'b1;
				end else if (f == FUNC_RAY) begin
					t = lim;
					r.region = idx;
					// lower plane wins ties with the limit
					den = plane_dot(idx, dx, dy, dz) / ONE30;
					if (den < 0) begin
						t1 = ray_div(diff_sat(plane_off[idx] * ONE30, plane_dot(idx, px, py, pz)), den);
						if (t1 <= t) begin
							t = t1;
							r.region = (idx == 0) ? 4'(n - 1) : idx - 4'd1;
							r.hx = 32'(plane_nx[idx]);
							r.hy = 32'(plane_ny[idx]);
							r.hz = 32'(plane_nz[idx]);
							r.crossed = 1'b1;
						end
					end
					den = plane_dot(up_j, dx, dy, dz) / ONE30;
					if (den > 0) begin
						t2 = ray_div(diff_sat(plane_off[up_j] * ONE30, plane_dot(up_j, px, py, pz)), den);
						if (t2 < t) begin
							t = t2;
							r.region = 4'(up_j);
							r.hx = 32'(-plane_nx[up_j]);
							r.hy = 32'(-plane_ny[up_j]);
							r.hz = 32'(-plane_nz[up_j]);
							r.crossed = 1'b1;
						end
					end
					r.distance = 32'(t);
				end else begin
					t1 = diff_sat(plane_dot(idx, px, py, pz), plane_off[idx] * ONE30);
					t2 = diff_sat(plane_off[up_j] * ONE30, plane_dot(up_j, px, py, pz));
					m = (t1 < t2) ? t1 : t2;
					r.distance = 32'(clip32(66'(m / ONE30)));
				end
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		planes_used = 2;
		for (int k = 0; k < MAX_PLANES; k++) begin
			plane_nx[k] = 0;
			plane_ny[k] = 0;
			plane_nz[k] = 0;
			plane_off[k] = 0;
		end
	end

	// register writes, accepted items and results, all sampled at the rising edge
	always @(posedge clk) begin
		sector_result_t want;
		if (arst_n) begin
			if (cfg_we) begin
				planes_used = (cfg_wdata < 2) ? 2 : (cfg_wdata > MAX_PLANES) ? MAX_PLANES : cfg_wdata;
			end
			if (done) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no item waiting", 1, 0);
				end else begin
					want = expected_results.pop_front();
					if (region !== want.region) report_mismatch("region", region, want.region);
					if (distance !== want.distance) report_mismatch("distance", distance, want.distance);
					if (crossed !== want.crossed) report_mismatch("crossed", crossed, want.crossed);
					if (hit_norm_x !== want.hx) report_mismatch("hit_norm_x", hit_norm_x, want.hx);
					if (hit_norm_y !== want.hy) report_mismatch("hit_norm_y", hit_norm_y, want.hy);
					if (hit_norm_z !== want.hz) report_mismatch("hit_norm_z", hit_norm_z, want.hz);
					if (bad_index !== want.bad) report_mismatch("bad_index", bad_index, want.bad);
				end
			end
			if (start && !busy) begin
				want = predict_sector(func, index, pos_x, pos_y, pos_z,
					norm_clip(dir_x), norm_clip(dir_y), norm_clip(dir_z), longint'(limit));
				expected_results = {expected_results, want};
			end
		end
	end
endmodule

>>> test/tb_top.sv
// Testbench top: clock, reset, stimulus and verdict for the angular sector ray geometry block.
`timescale 1ns / 1ps
module tb_top;
	import asrg_pkg::*;

	localparam int MAX_PLANES = 16;
	localparam int ITEM_TOTAL = 1250;
	localparam int SETTLE_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [4:0] cfg_wdata = '0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] func = '0;
	logic [3:0] index = '0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic signed [31:0] limit = '0;
	logic done;
	logic [3:0] region;
	logic signed [31:0] distance;
	logic crossed;
	logic signed [31:0] hit_norm_x, hit_norm_y, hit_norm_z;
	logic bad_index;
	int errors;
	int pending;
	int planes_now = 2;

	always #5 clk = ~clk;

	angular_sector_ray_geometry #(.MAX_PLANES(MAX_PLANES)) u_dut (.*);

	asrg_checker #(.MAX_PLANES(MAX_PLANES)) u_chk (.*);

	// hand one item over; start is held until the block takes it
	task automatic send_item(logic [1:0] f, logic [3:0] idx, logic signed [31:0] px,
			logic signed [31:0] py, logic signed [31:0] pz, logic signed [31:0] dx,
			logic signed [31:0] dy, logic signed [31:0] dz, logic signed [31:0] lim);
		@(negedge clk);
		while (busy) @(negedge clk);
		start <= 1'b1;
		func <= f;
		index <= idx;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		dir_x <= dx;
		dir_y <= dy;
		dir_z <= dz;
		limit <= lim;
		@(negedge clk);
		start <= 1'b0;
	endtask

	// register write once every result is in and the block has settled
	task automatic write_plane_count(logic [4:0] v);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		planes_now = (v < 2) ? 2 : (v > MAX_PLANES) ? MAX_PLANES : v;
	endtask

	// plane k of an even fan around the z axis, normal pointing into sector k
	task automatic write_fan_plane(int k, int n, logic signed [31:0] off);
		real a;
		a = 6.283185307179586 * k / n;
		send_item(FUNC_WRITE, 4'(k), $urandom, $urandom, $urandom,
			$rtoi(-$sin(a) * 1073741823.0), $rtoi($cos(a) * 1073741823.0), 0, off);
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(2 * 65536 * 64)) - 65536 * 64;
			2: return $signed($urandom_range(2 * 65536 * 4)) - 65536 * 4;
			default: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_dir();
		if ($urandom_range(9) == 0) return $urandom;
		return $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
	endfunction

	function automatic logic signed [31:0] rand_limit();
		if ($urandom_range(4) == 0) return $urandom;
		return $urandom_range(65536 * 512);
	endfunction

	initial begin
		logic [1:0] f;
		logic [3:0] idx;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// directed: every table entry written, with clamping extremes on entry 15
		for (int k = 0; k < MAX_PLANES; k++) write_fan_plane(k, MAX_PLANES, 0);
		send_item(FUNC_WRITE, 4'd15, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh4000_0001,
			32'sh7FFF_FFFF);
		send_item(FUNC_NEAR, 4'd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0, 0);
		send_item(FUNC_RAY, 4'd0, 32'sh0001_0000, 32'sh0000_8000, 0, 32'sh4000_0000, 0, 0,
			32'sh7FFF_FFFF);
		send_item(FUNC_RAY, 4'd2, 0, 0, 0, 0, 0, 0, 0);
		write_plane_count(5'd31);
		write_fan_plane(15, MAX_PLANES, 0);
		send_item(FUNC_LOCATE, 4'd0, 32'sh0010_0000, 32'sh0001_0000, 0, 0, 0, 0, 0);
		send_item(FUNC_LOCATE, 4'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, 0);
		send_item(FUNC_RAY, 4'd15, 32'sh0010_0000, 32'shFFFF_0000, 0, 0, 32'sh4000_0000, 0,
			32'sh0100_0000);
		send_item(FUNC_RAY, 4'd3, 32'sh0010_0000, 32'sh0008_0000, 0, 32'shC000_0000,
			32'sh0000_0000, 0, 0);
		send_item(FUNC_NEAR, 4'd7, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 0);
		write_plane_count(5'd0);
		send_item(FUNC_RAY, 4'd2, 0, 0, 0, 32'sh4000_0000, 0, 0, 0);
		send_item(FUNC_WRITE, 4'd9, 0, 0, 0, 0, 32'sh4000_0000, 0, 0);
		send_item(FUNC_NEAR, 4'd1, 32'sh0001_0000, 32'sh0001_0000, 0, 0, 0, 0, 0);

		// random: mostly queries on a fan of planes, with plane rewrites and count changes
		for (int i = 0; i < ITEM_TOTAL; i++) begin
			if (i % 150 == 149) begin
				write_plane_count(5'($urandom));
				if ($urandom_range(1))
					for (int k = 0; k < planes_now; k++) write_fan_plane(k, planes_now, 0);
			end
			if (i == 700) while (pending != 0) @(negedge clk);
			if ((i < 400 || i > 600) && $urandom_range(99) < 36)
				repeat ($urandom_range(1, 60)) @(negedge clk);
			f = $urandom_range(9) == 0 ? FUNC_WRITE : 2'($urandom_range(1, 3));
			idx = $urandom_range(7) == 0 ? 4'($urandom) : 4'($urandom_range(planes_now - 1));
			if (f == FUNC_WRITE)
				send_item(f, idx, $urandom, $urandom, $urandom, rand_dir(), rand_dir(),
					rand_dir(), $urandom_range(3) == 0 ? $urandom : 0);
			else
				send_item(f, idx, rand_coord(), rand_coord(), rand_coord(), rand_dir(),
					rand_dir(), rand_dir(), rand_limit());
		end

		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#50ms;
		$display("Mismatches found");
		$finish;
	end
endmodule
